// ===== src/abmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Batch motion detector package
// Widths, constants and small arithmetic helpers shared by the detector files.
// ----------------------------------------------------------------------------
package abmd_pkg;

	localparam int AXIS_W = 13;

	localparam logic signed [AXIS_W:0] AXIS_SHIFT      = 14'sd4000;
	localparam logic [AXIS_W-1:0]      THRESHOLD_RESET = 13'd1000;

	typedef logic [AXIS_W-1:0]        axis_t;
	typedef logic signed [AXIS_W-1:0] accel_t;

	// Offset a raw sample into the positive range; anything still below zero clamps to zero.
	function automatic axis_t shift_axis(input accel_t raw);
		logic signed [AXIS_W:0] v;
		v = {raw[AXIS_W-1], raw} + AXIS_SHIFT;
		return v[AXIS_W] ? '0 : v[AXIS_W-1:0];
	endfunction

	function automatic axis_t abs_diff(input axis_t a, input axis_t b);
		return (a < b) ? (b - a) : (a - b);
	endfunction

endpackage

// ===== src/abmd_ifs.sv =====
// ----------------------------------------------------------------------------
// Batch motion detector channels
// Valid/ready channels for samples, results and the threshold register.
// ----------------------------------------------------------------------------
interface abmd_sample_if;
	import abmd_pkg::*;
	logic   valid;
	logic   ready;
	accel_t accel_x;
	accel_t accel_y;
	accel_t accel_z;
	logic   during_vibration;
	logic   last_sample;

	modport source (output valid, accel_x, accel_y, accel_z, during_vibration, last_sample,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, during_vibration, last_sample,
		output ready);
endinterface

interface abmd_result_if;
	import abmd_pkg::*;
	logic  valid;
	logic  ready;
	axis_t max_deviation;
	logic  alarm;
	logic  discarded;
	logic  overflowed;

	modport source (output valid, max_deviation, alarm, discarded, overflowed, input ready);
	modport sink (input valid, max_deviation, alarm, discarded, overflowed, output ready);
endinterface

interface abmd_cfg_if;
	import abmd_pkg::*;
	logic  valid;
	logic  ready;
	axis_t alarm_threshold;

	modport source (output valid, alarm_threshold, input ready);
	modport sink (input valid, alarm_threshold, output ready);
endinterface

// ===== src/accel_batch_motion_detector.sv =====
// ----------------------------------------------------------------------------
// Accelerometer batch motion detector
// Collects a batch of samples, averages each axis and flags large deviations.
// ----------------------------------------------------------------------------
// Usage. Samples arrive as beats on the samples channel; each axis is offset
// by +4000 (clamped at zero), written to the sample store and added to its
// running sum. Samples beyond SAMPLE_DEPTH are dropped and flag an overflow.
// The beat marked last_sample closes the batch, and exactly one result beat
// follows on the results channel. The cfg channel writes alarm_threshold and
// is always ready; write it only while the detector is idle.
// Throughput: one sample per cycle while a batch is being collected. After
// the last beat the samples channel is held off while three restoring
// dividers form the axis averages (one quotient bit per cycle) and the
// store is read back one entry per cycle to find the largest deviation.
// A spoiled batch skips both and goes straight to the finishing state,
// which loads its result once the output register is free.
// The result sits in an output register; if the receiver stalls, the block
// keeps it and waits before finishing the next batch, but the following
// batch may already be collected. Reset clears all batch state and loads the
// threshold with 1000; the sample store itself is not cleared.
// ----------------------------------------------------------------------------
module accel_batch_motion_detector
	import abmd_pkg::*;
#(
	parameter int SAMPLE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	abmd_sample_if.sink   samples,
	abmd_cfg_if.sink      cfg,
	abmd_result_if.source results
);

	localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
	localparam int ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int SUM_W  = AXIS_W + CNT_W;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SAMPLE_DEPTH);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t           state_q;
	axis_t            thr_q;
	logic [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0] count_q;
	logic             spoiled_q;
	logic             ovf_q;
	logic [CNT_W-1:0] walk_idx_q;
	logic             rd_pend_s1;
	axis_t            max_q;
	logic             out_valid_q;
	axis_t            out_dev_q;
	logic             out_alarm_q;
	logic             out_disc_q;
	logic             out_ovf_q;

	logic             accept;
	logic             full;
	axis_t            sh_x, sh_y, sh_z;
	logic [3*AXIS_W-1:0] rd_data;
	axis_t            rd_x, rd_y, rd_z;
	axis_t            dev_x, dev_y, dev_z, dev_xy, dev_xyz;
	axis_t            avg_x, avg_y, avg_z;
	logic [2:0]       div_done;
	logic             div_start;
	logic             out_free;
	axis_t            fin_dev;

	assign samples.ready = (state_q == ST_ACCUM);
	assign cfg.ready     = 1'b1;
	assign accept        = samples.valid && samples.ready;
	assign full          = (count_q == DEPTH_CNT);
	assign div_start     = (state_q == ST_DIV_START);
	assign out_free      = !out_valid_q || results.ready;

	assign sh_x = shift_axis(samples.accel_x);
	assign sh_y = shift_axis(samples.accel_y);
	assign sh_z = shift_axis(samples.accel_z);

	abmd_sample_ram #(
		.DEPTH  (SAMPLE_DEPTH),
		.WIDTH  (3 * AXIS_W),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && !full),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data ({sh_x, sh_y, sh_z}),
		.rd_addr (walk_idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	abmd_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_x_q),
		.divisor(count_q), .done(div_done[0]), .quotient(avg_x)
	);
	abmd_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_y_q),
		.divisor(count_q), .done(div_done[1]), .quotient(avg_y)
	);
	abmd_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_z_q),
		.divisor(count_q), .done(div_done[2]), .quotient(avg_z)
	);

	// Deviation of the entry read back in the previous cycle against its axis average.
	assign rd_x    = rd_data[3*AXIS_W-1:2*AXIS_W];
	assign rd_y    = rd_data[2*AXIS_W-1:AXIS_W];
	assign rd_z    = rd_data[AXIS_W-1:0];
	assign dev_x   = abs_diff(rd_x, avg_x);
	assign dev_y   = abs_diff(rd_y, avg_y);
	assign dev_z   = abs_diff(rd_z, avg_z);
	assign dev_xy  = (dev_x > dev_y) ? dev_x : dev_y;
	assign dev_xyz = (dev_z > dev_xy) ? dev_z : dev_xy;

	// A spoiled batch reports no deviation at all.
	assign fin_dev = spoiled_q ? '0 : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			thr_q       <= THRESHOLD_RESET;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			count_q     <= '0;
			spoiled_q   <= 1'b0;
			ovf_q       <= 1'b0;
			walk_idx_q  <= '0;
			rd_pend_s1  <= 1'b0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
			out_dev_q   <= '0;
			out_alarm_q <= 1'b0;
			out_disc_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				thr_q <= cfg.alarm_threshold;
			end
			// In the finishing state a taken result is replaced by the new one below.
			if (out_valid_q && results.ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_ACCUM: begin
					if (accept) begin
						if (samples.during_vibration) begin
							spoiled_q <= 1'b1;
						end
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							sum_x_q <= sum_x_q + SUM_W'(sh_x);
							sum_y_q <= sum_y_q + SUM_W'(sh_y);
							sum_z_q <= sum_z_q + SUM_W'(sh_z);
							count_q <= count_q + 1'b1;
						end
						if (samples.last_sample) begin
							if (spoiled_q || samples.during_vibration) begin
								state_q <= ST_FINISH;
							end else begin
								state_q <= ST_DIV_START;
							end
						end
					end
				end
				ST_DIV_START: begin
					max_q      <= '0;
					walk_idx_q <= '0;
					rd_pend_s1 <= 1'b0;
					state_q    <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done[0]) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_idx_q < count_q) begin
						walk_idx_q <= walk_idx_q + 1'b1;
						rd_pend_s1 <= 1'b1;
					end else begin
						rd_pend_s1 <= 1'b0;
					end
					if (rd_pend_s1 && (dev_xyz > max_q)) begin
						max_q <= dev_xyz;
					end
					if ((walk_idx_q == count_q) && !rd_pend_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_dev_q   <= fin_dev;
						out_alarm_q <= !spoiled_q && (max_q > thr_q);
						out_disc_q  <= spoiled_q;
						out_ovf_q   <= ovf_q;
						sum_x_q     <= '0;
						sum_y_q     <= '0;
						sum_z_q     <= '0;
						count_q     <= '0;
						spoiled_q   <= 1'b0;
						ovf_q       <= 1'b0;
						state_q     <= ST_ACCUM;
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

	assign results.valid         = out_valid_q;
	assign results.max_deviation = out_dev_q;
	assign results.alarm         = out_alarm_q;
	assign results.discarded     = out_disc_q;
	assign results.overflowed    = out_ovf_q;

	// The fill count never runs past the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("sample count exceeds store depth");

	// The three axis dividers run in lock step.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_done[0] |-> (div_done[1] && div_done[2]))
		else $error("axis dividers out of step");

	// A discarded batch carries neither a deviation nor an alarm.
	a_discard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.discarded) |-> ((results.max_deviation == '0) && !results.alarm))
		else $error("discarded result carries a deviation or alarm");

	// A new result is only ever loaded from the finishing state.
	a_load_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside the finishing state");

endmodule

// ===== src/abmd_sample_ram.sv =====
// ----------------------------------------------------------------------------
// Sample store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module abmd_sample_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 39,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/abmd_div.sv =====
// ----------------------------------------------------------------------------
// Average divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module abmd_div
	import abmd_pkg::*;
#(
	parameter int SUM_W = 18,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output axis_t            quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam logic [STEP_W-1:0] STEPS = STEP_W'(SUM_W);

	logic [SUM_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	// The shifted remainder stays below twice the divisor, so one extra bit is enough.
	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				step_q <= STEPS;
				done_q <= 1'b0;
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				done_q <= (step_q == STEP_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q[AXIS_W-1:0];

endmodule

// ===== bench/abmd_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Batch motion detector result checker
// Watches the sample, threshold and result channels, predicts one verdict per
// closed batch and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module abmd_result_checker
	import abmd_pkg::*;
#(
	parameter int SAMPLE_DEPTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	abmd_sample_if smp,
	abmd_cfg_if    cfg,
	abmd_result_if res,
	output int     fail_count,
	output int     outstanding,
	output int     result_count,
	output int     alarm_count
);

	typedef struct {
		axis_t max_deviation;
		logic  alarm;
		logic  discarded;
		logic  overflowed;
	} verdict_t;

	verdict_t verdict_q[$];
	verdict_t oldest;

	// Shadow copy of the batch being collected and of the threshold register.
	axis_t stored [3][SAMPLE_DEPTH];
	int    axis_sum [3];
	int    stored_n;
	logic  spoiled;
	logic  overflow;
	axis_t threshold;

	int mismatches = 0;
	int checked    = 0;
	int alarms     = 0;

	assign fail_count   = mismatches;
	assign result_count = checked;
	assign alarm_count  = alarms;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic axis_t offset_axis(input accel_t raw);
		int v;
		v = int'(raw) + int'(AXIS_SHIFT);
		if (v < 0) begin
			v = 0;
		end
		return axis_t'(v);
	endfunction

	function automatic verdict_t close_batch();
		verdict_t v;
		int       mean [3];
		int       dev;
		int       worst;
		worst        = 0;
		v.discarded  = spoiled;
		v.overflowed = overflow;
		if (spoiled) begin
			v.max_deviation = '0;
			v.alarm         = 1'b0;
			return v;
		end
		for (int a = 0; a < 3; a++) begin
			mean[a] = (stored_n == 0) ? 0 : axis_sum[a] / stored_n;
		end
		for (int i = 0; i < stored_n; i++) begin
			for (int a = 0; a < 3; a++) begin
				dev = int'(stored[a][i]) - mean[a];
				if (dev < 0) begin
					dev = -dev;
				end
				if (dev > worst) begin
					worst = dev;
				end
			end
		end
		v.max_deviation = axis_t'(worst);
		v.alarm         = worst > int'(threshold);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q.delete();
			axis_sum    = '{default: 0};
			stored_n    = 0;
			spoiled     = 1'b0;
			overflow    = 1'b0;
			threshold   = THRESHOLD_RESET;
			outstanding <= 0;
		end else begin
			// Results are checked before this edge's sample is taken in, so a
			// verdict pushed now can never be matched against a beat of the same edge.
			if (res.valid && res.ready) begin
				checked++;
				if (verdict_q.size() == 0) begin
					report($sformatf("result %0d arrived with none expected", checked));
				end else begin
					oldest = verdict_q.pop_front();
					if (res.max_deviation !== oldest.max_deviation) begin
						report($sformatf("result %0d: max_deviation is %0d, expected %0d",
							checked, res.max_deviation, oldest.max_deviation));
					end
					if (res.alarm !== oldest.alarm) begin
						report($sformatf("result %0d: alarm is %b, expected %b",
							checked, res.alarm, oldest.alarm));
					end
					if (res.discarded !== oldest.discarded) begin
						report($sformatf("result %0d: discarded is %b, expected %b",
							checked, res.discarded, oldest.discarded));
					end
					if (res.overflowed !== oldest.overflowed) begin
						report($sformatf("result %0d: overflowed is %b, expected %b",
							checked, res.overflowed, oldest.overflowed));
					end
					if (oldest.alarm) begin
						alarms++;
					end
				end
			end

			if (cfg.valid && cfg.ready) begin
				threshold = cfg.alarm_threshold;
			end

			if (smp.valid && smp.ready) begin
				if (smp.during_vibration) begin
					spoiled = 1'b1;
				end
				if (stored_n < SAMPLE_DEPTH) begin
					stored[0][stored_n] = offset_axis(smp.accel_x);
					stored[1][stored_n] = offset_axis(smp.accel_y);
					stored[2][stored_n] = offset_axis(smp.accel_z);
					for (int a = 0; a < 3; a++) begin
						axis_sum[a] += int'(stored[a][stored_n]);
					end
					stored_n++;
				end else begin
					overflow = 1'b1;
				end
				if (smp.last_sample) begin
					verdict_q.push_back(close_batch());
					axis_sum = '{default: 0};
					stored_n = 0;
					spoiled  = 1'b0;
					overflow = 1'b0;
				end
			end

			outstanding <= verdict_q.size();
		end
	end

endmodule

// ===== bench/accel_batch_motion_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Batch motion detector testbench
// Drives batches of accelerometer samples and threshold writes into the
// detector, with a checker alongside that predicts and compares every result.
// ----------------------------------------------------------------------------
module accel_batch_motion_detector_test;
	import abmd_pkg::*;

	localparam int DEPTH = 16;
	// This pause comfortably covers the processing of a full batch after its
	// last beat, before the threshold is touched.
	localparam int SETTLE_CYCLES = 80;
	// Cycles with no beat on any channel before the run is declared hung.
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 510;
	localparam int PHASES = 6;

	typedef enum int {
		AXES_SPREAD,
		AXES_CLUSTER,
		AXES_EXTREME
	} axes_style_t;

	logic clk = 1'b0;
	logic arst_n;

	abmd_sample_if smp_ch();
	abmd_cfg_if    cfg_ch();
	abmd_result_if res_ch();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent    = 0;
	int batches_sent  = 0;
	int idle_cycles   = 0;

	int fail_count;
	int outstanding;
	int result_count;
	int alarm_count;

	always #1 clk = ~clk;

	accel_batch_motion_detector #(
		.SAMPLE_DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_ch),
		.cfg     (cfg_ch),
		.results (res_ch)
	);

	abmd_result_checker #(
		.SAMPLE_DEPTH(DEPTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (smp_ch),
		.cfg          (cfg_ch),
		.res          (res_ch),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.result_count (result_count),
		.alarm_count  (alarm_count)
	);

	// The receiver withdraws ready at random, in the proportion that the
	// current idling pattern asks for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: any beat on any channel restarts the count. A long run of
	// silence means the detector has stopped answering, so the run ends there.
	always @(posedge clk) begin
		if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("no beat on any channel for %0d cycles", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one sample beat and returns at the edge where it is taken. Valid
	// is left high afterwards, so back-to-back beats never drop and raise it
	// in the same step; a gap, if one is drawn, lowers it first.
	task automatic send_sample(input accel_t x, input accel_t y, input accel_t z,
		input logic vib, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			smp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		smp_ch.valid            <= 1'b1;
		smp_ch.accel_x          <= x;
		smp_ch.accel_y          <= y;
		smp_ch.accel_z          <= z;
		smp_ch.during_vibration <= vib;
		smp_ch.last_sample      <= is_last;
		@(posedge clk);
		while (!smp_ch.ready) begin
			@(posedge clk);
		end
		items_sent++;
		if (is_last) begin
			batches_sent++;
		end
	endtask

	// Stops the sender, waits for every predicted result to come back and
	// then lets the detector settle, so that the threshold can be rewritten
	// while it is idle.
	task automatic drain_and_settle();
		smp_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input axis_t value);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.alarm_threshold <= value;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// One axis value. Clustered values sit within a spread of a centre, which
	// keeps deviations close to the smaller thresholds; extremes hit the ends
	// of the range and the edge of the clamp at zero after the offset.
	function automatic accel_t pick_axis(input axes_style_t style, input int centre,
		input int spread);
		int v;
		case (style)
			AXES_SPREAD: begin
				v = int'(accel_t'($urandom));
			end
			AXES_EXTREME: begin
				case ($urandom_range(4))
					0:       v = -4096;
					1:       v = 4095;
					2:       v = -4000;
					3:       v = -4001;
					default: v = 0;
				endcase
			end
			default: begin
				v = centre + int'($urandom_range(2 * spread)) - spread;
				if (v < -4096) begin
					v = -4096;
				end else if (v > 4095) begin
					v = 4095;
				end
			end
		endcase
		return accel_t'(v);
	endfunction

	// A random batch of the given length. One sample, at spoil_at, is marked
	// as taken during vibration; a negative spoil_at leaves the batch clean.
	task automatic send_batch(input int len, input int spoil_at, input axes_style_t style);
		int cx;
		int cy;
		int cz;
		int spread;
		cx     = int'($urandom_range(8191)) - 4096;
		cy     = int'($urandom_range(8191)) - 4096;
		cz     = int'($urandom_range(8191)) - 4096;
		spread = int'($urandom_range(700));
		for (int i = 0; i < len; i++) begin
			send_sample(pick_axis(style, cx, spread), pick_axis(style, cy, spread),
				pick_axis(style, cz, spread), i == spoil_at, i == len - 1);
		end
	endtask

	initial begin
		int          goal;
		int          len;
		int          spoil_at;
		int          pick;
		axes_style_t style;

		arst_n                  <= 1'b0;
		smp_ch.valid            <= 1'b0;
		smp_ch.accel_x          <= '0;
		smp_ch.accel_y          <= '0;
		smp_ch.accel_z          <= '0;
		smp_ch.during_vibration <= 1'b0;
		smp_ch.last_sample      <= 1'b0;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.alarm_threshold  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the threshold left by reset.
		send_idle_pct = 28;
		recv_idle_pct = 82;

		// A lone sample: the most negative x clamps to zero, y is the top of
		// the range, and a single sample always has zero deviation.
		send_sample(-13'sd4096, 13'sd4095, 13'sd0, 1'b0, 1'b1);

		// Both ends of the range in one batch: the largest deviation there is,
		// well above the threshold.
		send_sample(-13'sd4096, -13'sd4096, -13'sd4096, 1'b0, 1'b0);
		send_sample(13'sd4095, 13'sd4095, 13'sd4095, 1'b0, 1'b1);

		// The clamp boundary just around -4000, and a vibration beat in the
		// middle of the batch that throws the whole batch away.
		send_sample(-13'sd4001, -13'sd4000, -13'sd3999, 1'b0, 1'b0);
		send_sample(13'sd100, 13'sd200, 13'sd300, 1'b1, 1'b0);
		send_sample(13'sd0, 13'sd0, 13'sd0, 1'b0, 1'b1);

		// A full store alternating between +1000 and -1000, so the deviation
		// equals the reset threshold exactly and must not raise the alarm. The
		// extra last beat is beyond the store, must be ignored, and flags the
		// overflow while still closing the batch.
		for (int i = 0; i < DEPTH; i++) begin
			if (i % 2 == 0) begin
				send_sample(13'sd1000, 13'sd1000, 13'sd1000, 1'b0, 1'b0);
			end else begin
				send_sample(-13'sd1000, -13'sd1000, -13'sd1000, 1'b0, 1'b0);
			end
		end
		send_sample(13'sd4095, -13'sd4096, 13'sd4095, 1'b0, 1'b1);

		// Random part: two threshold settings under each idling pattern.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			drain_and_settle();
			case (phase)
				0:       write_threshold(axis_t'(0));
				1:       write_threshold(axis_t'(8191));
				2:       write_threshold(axis_t'($urandom_range(8191)));
				3:       write_threshold(axis_t'($urandom_range(600)));
				4:       write_threshold(axis_t'($urandom_range(1500)));
				default: write_threshold(axis_t'(1));
			endcase

			goal = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < goal) begin
				// Mostly batches that fit the store, some very short ones, and a
				// few that run past it.
				pick = int'($urandom_range(19));
				if (pick < 2) begin
					len = int'($urandom_range(DEPTH + 4, DEPTH + 1));
				end else if (pick < 5) begin
					len = int'($urandom_range(2, 1));
				end else begin
					len = int'($urandom_range(DEPTH, 1));
				end
				spoil_at = ($urandom_range(6) == 0) ? int'($urandom_range(len - 1)) : -1;
				pick = int'($urandom_range(9));
				if (pick < 6) begin
					style = AXES_CLUSTER;
				end else if (pick < 9) begin
					style = AXES_SPREAD;
				end else begin
					style = AXES_EXTREME;
				end
				send_batch(len, spoil_at, style);
			end
		end

		drain_and_settle();

		$display("%0d samples in %0d batches, over six threshold settings and three idling patterns.",
			items_sent, batches_sent);
		$display("%0d results compared, %0d of them predicted to raise the alarm.",
			result_count, alarm_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/abmd_pkg.sv
src/abmd_ifs.sv
src/abmd_sample_ram.sv
src/abmd_div.sv
src/accel_batch_motion_detector.sv
bench/abmd_result_checker.sv
bench/accel_batch_motion_detector_test.sv
